/* hw/rtl/fcs_pkg.sv */
// shared constants, types and helpers for the corner strength block
package fcs_pkg;

   localparam int CIRCLE_POINTS = 16;
   localparam int HALF_POINTS   = CIRCLE_POINTS / 2;
   localparam int DIFF_W        = 8;
   localparam int WORD_W        = HALF_POINTS * DIFF_W;
   localparam int ARC_SHORT     = 9;
   localparam int ARC_LONG      = 12;

   localparam logic ARC_SEL_SHORT = 1'b0;
   localparam logic ARC_SEL_LONG  = 1'b1;

   typedef logic [DIFF_W-1:0]        diff_type;
   typedef logic [CIRCLE_POINTS-1:0] flags_type;
   typedef logic [WORD_W-1:0]        word_type;

   typedef struct packed {
      logic      brighter_enable;
      logic      darker_enable;
      flags_type brighter_flags;
      flags_type darker_flags;
      word_type  brighter_diffs_lo;
      word_type  brighter_diffs_hi;
      word_type  darker_diffs_lo;
      word_type  darker_diffs_hi;
   } item_type;

   function automatic diff_type min_diff(input diff_type a, input diff_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic diff_type max_diff(input diff_type a, input diff_type b);
      return (a > b) ? a : b;
   endfunction

endpackage

/* hw/rtl/fcs_req_if.sv */
// candidate pixel channel
interface fcs_req_if import fcs_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      brighter_enable;
   logic      darker_enable;
   flags_type brighter_flags;
   flags_type darker_flags;
   word_type  brighter_diffs_lo;
   word_type  brighter_diffs_hi;
   word_type  darker_diffs_lo;
   word_type  darker_diffs_hi;

   modport source (
      output valid, brighter_enable, darker_enable, brighter_flags, darker_flags,
             brighter_diffs_lo, brighter_diffs_hi, darker_diffs_lo, darker_diffs_hi,
      input  ready
   );
   modport sink (
      input  valid, brighter_enable, darker_enable, brighter_flags, darker_flags,
             brighter_diffs_lo, brighter_diffs_hi, darker_diffs_lo, darker_diffs_hi,
      output ready
   );
endinterface

/* hw/rtl/fcs_rsp_if.sv */
// corner strength result channel
interface fcs_rsp_if import fcs_pkg::*; ();
   logic     valid;
   logic     ready;
   diff_type strength;

   modport source (output valid, strength, input ready);
   modport sink (input valid, strength, output ready);
endinterface

/* hw/rtl/fcs_csr_if.sv */
// arc length register write channel
interface fcs_csr_if ();
   logic valid;
   logic ready;
   logic arc_length_select;

   modport source (output valid, arc_length_select, input ready);
   modport sink (input valid, arc_length_select, output ready);
endinterface

/* hw/rtl/fcs_arc_min.sv */
// minimum difference of each of the sixteen arcs of one polarity
module fcs_arc_min import fcs_pkg::*; (
   input  logic      enable,
   input  logic      long_arc,
   input  flags_type flags,
   input  word_type  diffs_lo,
   input  word_type  diffs_hi,
   output diff_type  arc_min [CIRCLE_POINTS]
);

   diff_type  d  [CIRCLE_POINTS];
   diff_type  p2 [CIRCLE_POINTS];
   diff_type  p4 [CIRCLE_POINTS];
   diff_type  p8 [CIRCLE_POINTS];
   flags_type f2;
   flags_type f4;
   flags_type f8;

   genvar k;

   for (k = 0; k < HALF_POINTS; k++) begin : g_unpack
      assign d[k]               = diffs_lo[k*DIFF_W +: DIFF_W];
      assign d[k + HALF_POINTS] = diffs_hi[k*DIFF_W +: DIFF_W];
   end

   // runs of 2, 4 and 8 positions starting at each position, wrapping round
   for (k = 0; k < CIRCLE_POINTS; k++) begin : g_runs
      assign p2[k] = min_diff(d[k],  d[(k + 1) % CIRCLE_POINTS]);
      assign f2[k] = flags[k] & flags[(k + 1) % CIRCLE_POINTS];
      assign p4[k] = min_diff(p2[k], p2[(k + 2) % CIRCLE_POINTS]);
      assign f4[k] = f2[k] & f2[(k + 2) % CIRCLE_POINTS];
      assign p8[k] = min_diff(p4[k], p4[(k + 4) % CIRCLE_POINTS]);
      assign f8[k] = f4[k] & f4[(k + 4) % CIRCLE_POINTS];
   end

   // nine = eight + one, twelve = eight + four
   for (k = 0; k < CIRCLE_POINTS; k++) begin : g_arcs
      diff_type min_short;
      diff_type min_long;
      logic     ok_short;
      logic     ok_long;
      logic     ok;

      assign min_short = min_diff(p8[k], d[(k + ARC_SHORT - 1) % CIRCLE_POINTS]);
      assign ok_short  = f8[k] & flags[(k + ARC_SHORT - 1) % CIRCLE_POINTS];
      assign min_long  = min_diff(p8[k], p4[(k + ARC_LONG - 4) % CIRCLE_POINTS]);
      assign ok_long   = f8[k] & f4[(k + ARC_LONG - 4) % CIRCLE_POINTS];
      assign ok        = enable & ((long_arc == ARC_SEL_LONG) ? ok_long : ok_short);
      assign arc_min[k] = !ok ? '0 : ((long_arc == ARC_SEL_LONG) ? min_long : min_short);
   end

endmodule

/* hw/rtl/fast_corner_strength.sv */
// FAST segment test corner strength, one candidate pixel per cycle while the result side keeps up
//
// Takes one candidate pixel item per cycle and returns its corner strength
// after acceptance: the item is registered, the sixteen arc
// minima of both polarities are formed and registered, then the maximum
// over all 32 is registered as the result. Throughput is one item per cycle
// whenever the result side keeps up; each stage holds its item while the
// next one is full, so a stalled result does not block the input until the
// pipeline has filled. The arc length register (0: 9 positions, 1: 12
// positions) may be written at any cycle while no item is in flight and
// is taken on every csr write.
module fast_corner_strength import fcs_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   fcs_req_if.sink   req_chan,
   fcs_rsp_if.source rsp_chan,
   fcs_csr_if.sink   csr_chan
);

   localparam int ARCS = 2 * CIRCLE_POINTS;

   logic     arc_sel_ff;
   logic     arc_sel_in;
   logic     in_valid_ff;
   logic     in_valid_in;
   item_type in_item_ff;
   logic     mid_valid_ff;
   logic     mid_valid_in;
   diff_type mid_min_ff [ARCS];
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   diff_type rsp_strength_ff;
   diff_type rsp_strength_in;

   logic     in_adv;
   logic     mid_adv;
   logic     rsp_adv;

   diff_type bright_min [CIRCLE_POINTS];
   diff_type dark_min   [CIRCLE_POINTS];
   diff_type t16 [CIRCLE_POINTS];
   diff_type t8  [CIRCLE_POINTS/2];
   diff_type t4  [CIRCLE_POINTS/4];
   diff_type t2  [CIRCLE_POINTS/8];

   // each stage moves on when it is empty or the next one is moving
   assign rsp_adv = !rsp_valid_ff || rsp_chan.ready;
   assign mid_adv = !mid_valid_ff || rsp_adv;
   assign in_adv  = !in_valid_ff  || mid_adv;

   assign req_chan.ready  = in_adv;
   assign csr_chan.ready  = 1'b1;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.strength = rsp_strength_ff;

   assign arc_sel_in   = csr_chan.valid ? csr_chan.arc_length_select : arc_sel_ff;
   assign in_valid_in  = in_adv  ? req_chan.valid : in_valid_ff;
   assign mid_valid_in = mid_adv ? in_valid_ff    : mid_valid_ff;
   assign rsp_valid_in = rsp_adv ? mid_valid_ff   : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         arc_sel_ff   <= ARC_SEL_SHORT;
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         arc_sel_ff   <= arc_sel_in;
         in_valid_ff  <= in_valid_in;
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_adv && req_chan.valid) begin
         in_item_ff.brighter_enable   <= req_chan.brighter_enable;
         in_item_ff.darker_enable     <= req_chan.darker_enable;
         in_item_ff.brighter_flags    <= req_chan.brighter_flags;
         in_item_ff.darker_flags      <= req_chan.darker_flags;
         in_item_ff.brighter_diffs_lo <= req_chan.brighter_diffs_lo;
         in_item_ff.brighter_diffs_hi <= req_chan.brighter_diffs_hi;
         in_item_ff.darker_diffs_lo   <= req_chan.darker_diffs_lo;
         in_item_ff.darker_diffs_hi   <= req_chan.darker_diffs_hi;
      end
   end

   fcs_arc_min u_bright (
      .enable   (in_item_ff.brighter_enable),
      .long_arc (arc_sel_ff),
      .flags    (in_item_ff.brighter_flags),
      .diffs_lo (in_item_ff.brighter_diffs_lo),
      .diffs_hi (in_item_ff.brighter_diffs_hi),
      .arc_min  (bright_min)
   );

   fcs_arc_min u_dark (
      .enable   (in_item_ff.darker_enable),
      .long_arc (arc_sel_ff),
      .flags    (in_item_ff.darker_flags),
      .diffs_lo (in_item_ff.darker_diffs_lo),
      .diffs_hi (in_item_ff.darker_diffs_hi),
      .arc_min  (dark_min)
   );

   always_ff @(posedge clock) begin
      if (mid_adv && in_valid_ff) begin
         for (int i = 0; i < CIRCLE_POINTS; i++) begin
            mid_min_ff[i]                 <= bright_min[i];
            mid_min_ff[i + CIRCLE_POINTS] <= dark_min[i];
         end
      end
   end

   // maximum over all arc minima, disqualified arcs already read as zero
   always_comb begin
      for (int i = 0; i < CIRCLE_POINTS; i++) begin
         t16[i] = max_diff(mid_min_ff[2*i], mid_min_ff[2*i + 1]);
      end
      for (int i = 0; i < CIRCLE_POINTS/2; i++) begin
         t8[i] = max_diff(t16[2*i], t16[2*i + 1]);
      end
      for (int i = 0; i < CIRCLE_POINTS/4; i++) begin
         t4[i] = max_diff(t8[2*i], t8[2*i + 1]);
      end
      for (int i = 0; i < CIRCLE_POINTS/8; i++) begin
         t2[i] = max_diff(t4[2*i], t4[2*i + 1]);
      end
      rsp_strength_in = max_diff(t2[0], t2[1]);
   end

   always_ff @(posedge clock) begin
      if (rsp_adv && mid_valid_ff) begin
         rsp_strength_ff <= rsp_strength_in;
      end
   end

endmodule

/* bench/tb.sv */
// self-checking bench for the corner strength block: queued driver, scoring monitor, watchdog
module tb import fcs_pkg::*; ();

   localparam int LONG_HOLD      = 300;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 250;

   logic clock;
   logic reset;

   fcs_req_if req_bus ();
   fcs_rsp_if rsp_bus ();
   fcs_csr_if csr_bus ();

   fast_corner_strength DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   item_type pixel_queue[$];
   diff_type expected_strengths[$];
   item_type driven_pixel;
   diff_type wanted_strength;
   logic     arc_sel;
   logic     steady;
   int       send_gap;
   int       take_gap;
   int       hold_left;
   int       hold_asks;
   int       hold_served;
   int       error_count;
   int       quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // best arc minimum of one polarity, arcs of span positions wrapping round
   function automatic diff_type polarity_strength(input flags_type flags,
                                                  input word_type lo, input word_type hi,
                                                  input int span);
      logic [2*WORD_W-1:0] diffs;
      diff_type best;
      diff_type lowest;
      diff_type d;
      logic whole;
      int pos;
      diffs = {hi, lo};
      best  = '0;
      for (int s = 0; s < CIRCLE_POINTS; s++) begin
         whole  = 1'b1;
         lowest = '1;
         for (int j = 0; j < span; j++) begin
            pos = (s + j) % CIRCLE_POINTS;
            if (!flags[pos]) whole = 1'b0;
            d = diffs[DIFF_W*pos +: DIFF_W];
            if (d < lowest) lowest = d;
         end
         if (whole && lowest > best) best = lowest;
      end
      return best;
   endfunction

   function automatic diff_type corner_strength(input item_type px, input logic sel);
      diff_type best;
      diff_type sc;
      int span;
      span = (sel == ARC_SEL_LONG) ? ARC_LONG : ARC_SHORT;
      best = '0;
      if (px.brighter_enable) begin
         sc = polarity_strength(px.brighter_flags, px.brighter_diffs_lo,
                                px.brighter_diffs_hi, span);
         if (sc > best) best = sc;
      end
      if (px.darker_enable) begin
         sc = polarity_strength(px.darker_flags, px.darker_diffs_lo,
                                px.darker_diffs_hi, span);
         if (sc > best) best = sc;
      end
      return best;
   endfunction

   function automatic item_type pixel(input logic be, input logic de,
                                      input flags_type bf, input flags_type df,
                                      input logic [2*WORD_W-1:0] bd,
                                      input logic [2*WORD_W-1:0] dd);
      item_type px;
      px.brighter_enable   = be;
      px.darker_enable     = de;
      px.brighter_flags    = bf;
      px.darker_flags      = df;
      px.brighter_diffs_lo = bd[WORD_W-1:0];
      px.brighter_diffs_hi = bd[2*WORD_W-1:WORD_W];
      px.darker_diffs_lo   = dd[WORD_W-1:0];
      px.darker_diffs_hi   = dd[2*WORD_W-1:WORD_W];
      return px;
   endfunction

   function automatic logic [2*WORD_W-1:0] ramp(input int first, input int step);
      logic [2*WORD_W-1:0] r;
      for (int k = 0; k < CIRCLE_POINTS; k++) r[DIFF_W*k +: DIFF_W] = diff_type'(first + step*k);
      return r;
   endfunction

   function automatic logic [2*WORD_W-1:0] random_diffs();
      logic [2*WORD_W-1:0] r;
      int mode;
      mode = $urandom_range(0, 4);
      r = {$urandom, $urandom, $urandom, $urandom};
      for (int k = 0; k < CIRCLE_POINTS; k++) begin
         case (mode)
            1: r[DIFF_W*k +: DIFF_W] = diff_type'($urandom_range(0, 3));
            2: r[DIFF_W*k +: DIFF_W] = r[DIFF_W-1:0];
            3: if ($urandom_range(0, 5) == 0) r[DIFF_W*k +: DIFF_W] = '0;
            4: if ($urandom_range(0, 3) != 0) r[DIFF_W*k +: DIFF_W] = '1;
            default: ;
         endcase
      end
      return r;
   endfunction

   // mostly runs of set positions so that arcs qualify, the rest noise or broken runs
   function automatic flags_type random_flags();
      flags_type run;
      int len;
      int rot;
      case ($urandom_range(0, 6))
         0: run = '1;
         1, 2, 3: begin
            len = $urandom_range(7, 16);
            run = (len == CIRCLE_POINTS) ? '1 : flags_type'((32'd1 << len) - 1);
            rot = $urandom_range(0, CIRCLE_POINTS - 1);
            run = (run << rot) | (run >> (CIRCLE_POINTS - rot));
            if ($urandom_range(0, 1)) run |= flags_type'($urandom) & flags_type'($urandom);
            if ($urandom_range(0, 3) == 0) run &= ~(flags_type'(1) << $urandom_range(0, 15));
         end
         4: run = flags_type'($urandom);
         5: run = flags_type'($urandom) | flags_type'($urandom);
         default: run = ~(flags_type'(1) << $urandom_range(0, 15));
      endcase
      return run;
   endfunction

   function automatic item_type random_pixel();
      return pixel($urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0,
                   random_flags(), random_flags(), random_diffs(), random_diffs());
   endfunction

   task automatic push_directed();
      pixel_queue.push_back(pixel(1'b0, 1'b0, '0, '0, '0, '0));
      pixel_queue.push_back(pixel(1'b1, 1'b1, '1, '1, '1, '1));
      // polarity disabled: everything passing, still nothing counts
      pixel_queue.push_back(pixel(1'b0, 1'b0, '1, '1, '1, '1));
      pixel_queue.push_back(pixel(1'b1, 1'b0, '1, '1, ramp(16, 13), '1));
      pixel_queue.push_back(pixel(1'b0, 1'b1, '1, '1, '1, ramp(250, -11)));
      // nine positions wrapping through position 0
      pixel_queue.push_back(pixel(1'b1, 1'b0, 16'hF01F, '0, ramp(5, 9), '0));
      pixel_queue.push_back(pixel(1'b0, 1'b1, '0, 16'h0FFF, '0,
                                  {$urandom, $urandom, $urandom, $urandom}));
      pixel_queue.push_back(pixel(1'b1, 1'b1, 16'h00FF, 16'hFF00, '1, '1));
      // the only nine-position arc holds a zero difference
      pixel_queue.push_back(pixel(1'b1, 1'b0, 16'h01FF, '1,
                                  ~({2*WORD_W{1'b0}} | (128'hFF << 24)), '1));
      pixel_queue.push_back(pixel(1'b1, 1'b1, '1, '1, {16{8'h10}}, {16{8'h80}}));
      pixel_queue.push_back(pixel(1'b1, 1'b1, 16'hAAAA, 16'h5555, '1, '1));
      pixel_queue.push_back(pixel(1'b1, 1'b1, 16'hFEFF, 16'hFFF7, ramp(1, 1), ramp(200, 3)));
   endtask

   task automatic wait_drained();
      while (pixel_queue.size() != 0 || req_bus.valid || expected_strengths.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_arc_sel(input logic sel);
      @(posedge clock);
      csr_bus.valid             <= 1'b1;
      csr_bus.arc_length_select <= sel;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      arc_sel = sel;
   endtask

   // sender: one item per handshake, random gap drawn after each accepted item
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) begin
            expected_strengths.push_back(corner_strength(driven_pixel, arc_sel));
            send_gap = steady ? 0 : $urandom_range(0, 4);
         end
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pixel_queue.size() != 0) begin
            driven_pixel = pixel_queue.pop_front();
            req_bus.valid             <= 1'b1;
            req_bus.brighter_enable   <= driven_pixel.brighter_enable;
            req_bus.darker_enable     <= driven_pixel.darker_enable;
            req_bus.brighter_flags    <= driven_pixel.brighter_flags;
            req_bus.darker_flags      <= driven_pixel.darker_flags;
            req_bus.brighter_diffs_lo <= driven_pixel.brighter_diffs_lo;
            req_bus.brighter_diffs_hi <= driven_pixel.brighter_diffs_hi;
            req_bus.darker_diffs_lo   <= driven_pixel.darker_diffs_lo;
            req_bus.darker_diffs_hi   <= driven_pixel.darker_diffs_hi;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver: scores each result item, stalls at random or for a long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         take_gap  = 0;
         hold_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_strengths.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result: strength %0d", rsp_bus.strength);
            end else begin
               wanted_strength = expected_strengths.pop_front();
               if (rsp_bus.strength !== wanted_strength) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("strength mismatch: expected %0d, got %0d",
                              wanted_strength, rsp_bus.strength);
               end
            end
            take_gap = steady ? 0 : $urandom_range(0, 4);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_served != hold_asks) begin
            hold_served = hold_asks;
            hold_left   = LONG_HOLD;
            rsp_bus.ready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", quiet_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset        = 1'b1;
      arc_sel      = ARC_SEL_SHORT;
      steady       = 1'b0;
      hold_asks    = 0;
      hold_served  = 0;
      error_count  = 0;
      quiet_cycles = 0;
      req_bus.valid             = 1'b0;
      req_bus.brighter_enable   = 1'b0;
      req_bus.darker_enable     = 1'b0;
      req_bus.brighter_flags    = '0;
      req_bus.darker_flags      = '0;
      req_bus.brighter_diffs_lo = '0;
      req_bus.brighter_diffs_hi = '0;
      req_bus.darker_diffs_lo   = '0;
      req_bus.darker_diffs_hi   = '0;
      rsp_bus.ready             = 1'b0;
      csr_bus.valid             = 1'b0;
      csr_bus.arc_length_select = ARC_SEL_SHORT;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_arc_sel(ARC_SEL_SHORT);
      push_directed();
      wait_drained();
      write_arc_sel(ARC_SEL_LONG);
      push_directed();
      wait_drained();

      for (int phase = 0; phase < 7; phase++) begin
         write_arc_sel(((phase % 2) == 0) ? ARC_SEL_SHORT : ARC_SEL_LONG);
         steady = (phase == 2 || phase == 5);
         // long receiver hold while the sender keeps offering
         if (phase == 4) hold_asks++;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pixel_queue.push_back(random_pixel());
            // sender pause mid-phase until everything has come back
            if (phase == 3 && n == PHASE_ITEMS / 2) wait_drained();
         end
         wait_drained();
      end

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
